### hw/rtl/greedy_text_line_justifier_unit_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the greedy text line justifier
// Shared concurrent assertion forms used by the checker.
// ---------------------------------------------------------------------------
`ifndef GREEDY_TEXT_LINE_JUSTIFIER_UNIT_DEFINES_SVH
`define GREEDY_TEXT_LINE_JUSTIFIER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define GTLJ_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define GTLJ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/gtlj_pkg.sv
// ---------------------------------------------------------------------------
// gtlj_pkg
// Types and constants of the greedy text line justifier.
// ---------------------------------------------------------------------------
package gtlj_pkg;

    localparam int MAX_WIDTH = 64;
    localparam int MAX_WORDS = 32;

    localparam int LEN_W   = 7;                      // word length, line width
    localparam int SP_W    = 6;                      // spaces_after
    localparam int ADDR_W  = $clog2(MAX_WORDS);      // word buffer index
    localparam int CNT_W   = $clog2(MAX_WORDS + 1);  // word count, 0..MAX_WORDS
    localparam int GAP_W   = (ADDR_W > 0) ? ADDR_W : 1;
    localparam int SUM_W   = LEN_W + 2;              // total + word + count

    localparam logic [LEN_W-1:0] LINE_WIDTH_RESET = LEN_W'(MAX_WIDTH % 128);
    localparam logic [SP_W-1:0]  SP_MAX           = '1;

    typedef struct packed {
        logic [LEN_W-1:0] word_length;
        logic             end_of_text;
    } word_item_t;

    typedef struct packed {
        logic [LEN_W-1:0] out_word_length;
        logic [SP_W-1:0]  spaces_after;
        logic             end_of_line;
        logic             last_result;
    } result_item_t;

endpackage

### hw/rtl/greedy_text_line_justifier_unit.sv
// ---------------------------------------------------------------------------
// greedy_text_line_justifier_unit
// Word lengths go in one item at a time and are packed greedily onto lines of
// line_width characters. When a word does not fit (or the buffer already holds
// MAX_WORDS words) the buffered line is sent out fully justified, one result
// item per word with its trailing space count: spare spaces split evenly over
// the gaps, leftmost gaps take the remainder, a lone word gets all the padding
// after it. end_of_text flushes the final line with single spaces and the rest
// of the padding after its last word. Space counts saturate at 63, padding
// clamps at zero. A flush primes the read of word 0, then walks the line one
// word per cycle through the single buffer read port while result_stall does
// not hold the output register; a justified line of two or more words first
// runs the shift-subtract divider. A new word is taken while the last result
// still waits in the output register.
// ---------------------------------------------------------------------------
module greedy_text_line_justifier_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [gtlj_pkg::LEN_W-1:0]          cfg_write_data,
    input  logic                                word_valid,
    output logic                                word_stall,
    input  gtlj_pkg::word_item_t                word_item,
    output logic                                result_valid,
    input  logic                                result_stall,
    output gtlj_pkg::result_item_t              result_item
);

    // sequencer codes
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DIV    = 3'd1;  // spaces / gaps, one bit a cycle
    localparam logic [2:0] S_PRIME  = 3'd2;  // read of word 0 in flight
    localparam logic [2:0] S_WALK   = 3'd3;  // one word out per cycle unless result_stall holds the output
    localparam logic [2:0] S_APPEND = 3'd4;  // buffer write of the new word

    localparam int          DIV_STEPS = gtlj_pkg::LEN_W;
    localparam logic [2:0]  DIV_LAST  = 3'(DIV_STEPS - 1);

    logic [2:0]                   state_reg;
    logic [gtlj_pkg::LEN_W-1:0]   line_width_reg;
    logic [gtlj_pkg::CNT_W-1:0]   count_reg;       // words on current line
    logic [gtlj_pkg::LEN_W-1:0]   total_reg;       // letters on current line
    logic                         result_valid_reg;
    gtlj_pkg::result_item_t       result_item_reg;

    // datapath, no reset needed
    logic [gtlj_pkg::LEN_W-1:0]   word_reg;
    logic                         eot_reg;
    logic                         final_reg;       // flush is the end-of-text line
    logic [gtlj_pkg::CNT_W-1:0]   n_reg;           // words in the line being sent
    logic [gtlj_pkg::LEN_W-1:0]   spaces_reg;
    logic [gtlj_pkg::LEN_W-1:0]   rest_reg;        // padding after last word, final line
    logic [gtlj_pkg::LEN_W-1:0]   quo_reg;         // dividend in, quotient out
    logic [gtlj_pkg::GAP_W-1:0]   rem_reg;
    logic [2:0]                   div_cnt_reg;
    logic [gtlj_pkg::ADDR_W-1:0]  j_reg;

    // word buffer
    logic [gtlj_pkg::LEN_W-1:0]   buf_mem [gtlj_pkg::MAX_WORDS];
    logic [gtlj_pkg::LEN_W-1:0]   rd_data_reg;
    logic                         rd_en;
    logic [gtlj_pkg::ADDR_W-1:0]  rd_addr;
    logic                         wr_en;

    logic                         accept;
    logic                         need_flush;
    logic [gtlj_pkg::SUM_W-1:0]   fit_sum;
    logic [gtlj_pkg::LEN_W-1:0]   spaces_old;
    logic [gtlj_pkg::LEN_W-1:0]   total_new;
    logic [gtlj_pkg::LEN_W-1:0]   spaces_new;
    logic [gtlj_pkg::LEN_W-1:0]   rest_new;
    logic [gtlj_pkg::GAP_W-1:0]   gaps;
    logic [gtlj_pkg::GAP_W:0]     trial;
    logic                         trial_ok;
    logic                         advance;
    logic                         last_word;
    logic [gtlj_pkg::LEN_W:0]     sp_full;
    logic [gtlj_pkg::SP_W-1:0]    sp_sat;

    assign word_stall   = (state_reg != S_IDLE);
    assign accept       = word_valid && !word_stall;
    assign result_valid = result_valid_reg;
    assign result_item  = result_item_reg;

    // fit test against the line as it stands
    assign fit_sum = gtlj_pkg::SUM_W'(total_reg) + gtlj_pkg::SUM_W'(word_item.word_length)
                   + gtlj_pkg::SUM_W'(count_reg);
    assign need_flush = (count_reg != '0)
                     && ((count_reg >= gtlj_pkg::CNT_W'(gtlj_pkg::MAX_WORDS))
                      || (fit_sum > gtlj_pkg::SUM_W'(line_width_reg)));
    assign spaces_old = (line_width_reg > total_reg) ? (line_width_reg - total_reg) : '0;

    // line after appending the buffered word; total stays below 128 by the fit rule
    assign total_new  = total_reg + word_reg;
    assign spaces_new = (line_width_reg > total_new) ? (line_width_reg - total_new) : '0;
    assign rest_new   = (spaces_new > gtlj_pkg::LEN_W'(count_reg))
                      ? (spaces_new - gtlj_pkg::LEN_W'(count_reg)) : '0;

    // restoring divider step
    assign gaps     = gtlj_pkg::GAP_W'(n_reg - 1'b1);
    assign trial    = {rem_reg, quo_reg[gtlj_pkg::LEN_W-1]};
    assign trial_ok = (trial >= {1'b0, gaps});

    // walk: output register takes a word whenever it is empty or being drained
    assign advance   = !result_valid_reg || !result_stall;
    assign last_word = ({1'b0, j_reg} == (n_reg - 1'b1));

    always_comb
    begin
        if (final_reg)
        begin
            sp_full = last_word ? {1'b0, rest_reg} : (gtlj_pkg::LEN_W+1)'(1);
        end
        else if (last_word)
        begin
            sp_full = (n_reg == gtlj_pkg::CNT_W'(1)) ? {1'b0, spaces_reg} : '0;
        end
        else
        begin
            sp_full = {1'b0, quo_reg}
                    + (gtlj_pkg::LEN_W+1)'(j_reg < gtlj_pkg::ADDR_W'(rem_reg));
        end
        sp_sat = (sp_full > (gtlj_pkg::LEN_W+1)'(gtlj_pkg::SP_MAX))
               ? gtlj_pkg::SP_MAX : sp_full[gtlj_pkg::SP_W-1:0];
    end

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        if (state_reg == S_PRIME)
        begin
            rd_en = 1'b1;
        end
        else if (state_reg == S_WALK && advance && !last_word)
        begin
            rd_en   = 1'b1;
            rd_addr = j_reg + 1'b1;
        end
    end

    assign wr_en = (state_reg == S_APPEND);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            buf_mem[count_reg[gtlj_pkg::ADDR_W-1:0]] <= word_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= buf_mem[rd_addr];
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            line_width_reg   <= gtlj_pkg::LINE_WIDTH_RESET;
            count_reg        <= '0;
            total_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                line_width_reg <= cfg_write_data;
            end

            // a walk step loads the output register, otherwise it drains
            if (state_reg == S_WALK && advance)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (!need_flush)
                        begin
                            state_reg <= S_APPEND;
                        end
                        else if (count_reg == gtlj_pkg::CNT_W'(1))
                        begin
                            state_reg <= S_PRIME;
                        end
                        else
                        begin
                            state_reg <= S_DIV;
                        end
                    end
                end
                S_DIV:
                begin
                    if (div_cnt_reg == DIV_LAST)
                    begin
                        state_reg <= S_PRIME;
                    end
                end
                S_PRIME:
                begin
                    state_reg <= S_WALK;
                end
                S_WALK:
                begin
                    if (advance && last_word)
                    begin
                        count_reg <= '0;
                        total_reg <= '0;
                        state_reg <= final_reg ? S_IDLE : S_APPEND;
                    end
                end
                S_APPEND:
                begin
                    count_reg <= count_reg + 1'b1;
                    total_reg <= total_new;
                    state_reg <= eot_reg ? S_PRIME : S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    word_reg    <= word_item.word_length;
                    eot_reg     <= word_item.end_of_text;
                    final_reg   <= 1'b0;
                    n_reg       <= count_reg;
                    spaces_reg  <= spaces_old;
                    quo_reg     <= spaces_old;
                    rem_reg     <= '0;
                    div_cnt_reg <= '0;
                end
            end
            S_DIV:
            begin
                rem_reg     <= trial_ok ? gtlj_pkg::GAP_W'(trial - {1'b0, gaps})
                                        : gtlj_pkg::GAP_W'(trial);
                quo_reg     <= {quo_reg[gtlj_pkg::LEN_W-2:0], trial_ok};
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
            S_PRIME:
            begin
                j_reg <= '0;
            end
            S_WALK:
            begin
                if (advance)
                begin
                    result_item_reg.out_word_length <= rd_data_reg;
                    result_item_reg.spaces_after    <= sp_sat;
                    result_item_reg.end_of_line     <= last_word;
                    result_item_reg.last_result     <= last_word && (final_reg || !eot_reg);
                    if (!last_word)
                    begin
                        j_reg <= j_reg + 1'b1;
                    end
                end
            end
            S_APPEND:
            begin
                // set up the end-of-text line; unused when eot_reg is low
                final_reg  <= 1'b1;
                n_reg      <= count_reg + 1'b1;
                spaces_reg <= spaces_new;
                rest_reg   <= rest_new;
            end
            default:
            begin
                j_reg <= j_reg;
            end
        endcase
    end

endmodule

### hw/rtl/gtlj_checker.sv
// ---------------------------------------------------------------------------
// gtlj_checker
// Port-level checks of the greedy text line justifier, bound to the top level.
// ---------------------------------------------------------------------------
`include "greedy_text_line_justifier_unit_defines.svh"

module gtlj_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   word_valid,
    input logic                   word_stall,
    input gtlj_pkg::result_item_t result_item,
    input logic                   result_valid,
    input logic                   result_stall
);

    // stalled result holds
    `GTLJ_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(result_item), "stalled result item changed")

    // every accepted word makes the block busy in the next cycle
    `GTLJ_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, word_valid && !word_stall, word_stall, "word taken back to back")

    // the final result of a word always closes a line
    `GTLJ_ASSERT_SAME(a_last_is_eol, clk, rst_n, result_valid && result_item.last_result, result_item.end_of_line, "last result not at end of line")

    // results only come out of a flush, which runs with the input stalled
    `GTLJ_ASSERT_SAME(a_result_from_flush, clk, rst_n, $rose(result_valid), $past(word_stall), "result appeared outside a flush")

endmodule

bind greedy_text_line_justifier_unit gtlj_checker u_gtlj_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .word_valid   (word_valid),
    .word_stall   (word_stall),
    .result_item  (result_item),
    .result_valid (result_valid),
    .result_stall (result_stall)
);

### tb/tb_greedy_text_line_justifier_unit.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_greedy_text_line_justifier_unit
// Self-checking bench for the greedy line justifier. A short table of word
// items covers the extremes and the corner cases. Random phases follow, each
// at a fresh line width. A local justifier predicts every result item and
// the bench compares each one field by field as it leaves the block. Both
// channels idle and stall at random.
// ---------------------------------------------------------------------------
module tb_greedy_text_line_justifier_unit;

    localparam int SETTLE_CYCLES  = 60;
    localparam int WATCHDOG_LIMIT = 4000;  // cycles with no item moving
    localparam int RANDOM_ITEMS   = 240;
    localparam int MAX_REPORTS    = 10;

    // kinds of rows in the directed table
    typedef enum logic [1:0] {
        ROW_WIDTH,   // line_width register write
        ROW_WORD,    // word item, checked against the predictor
        ROW_TYPED    // word item with one result typed in by hand
    } row_kind_t;

    typedef struct {
        row_kind_t              kind;
        int                     value;     // width or word length
        bit                     eot;
        gtlj_pkg::result_item_t fixed;     // only for ROW_TYPED
    } stim_row_t;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       cfg_write_en;
    logic [gtlj_pkg::LEN_W-1:0] cfg_write_data;
    logic                       word_valid;
    logic                       word_stall;
    gtlj_pkg::word_item_t       word_item;
    logic                       result_valid;
    logic                       result_stall;
    gtlj_pkg::result_item_t     result_item;

    greedy_text_line_justifier_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .word_valid     (word_valid),
        .word_stall     (word_stall),
        .word_item      (word_item),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .result_item    (result_item)
    );

    // 20 ns period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // -----------------------------------------------------------------------
    // Predictor: local copy of the line buffer and of the width register
    // -----------------------------------------------------------------------
    logic [gtlj_pkg::LEN_W-1:0] cur_width;
    logic [gtlj_pkg::LEN_W-1:0] line_lens [gtlj_pkg::MAX_WORDS];
    int                         line_letters;
    int                         line_words;

    gtlj_pkg::result_item_t step_results[$];     // results of the word being predicted
    gtlj_pkg::result_item_t awaited_results[$];  // results still due from the block

    stim_row_t directed_rows[$];

    bit no_idle;        // when set, neither side idles or stalls
    int fault_count;
    int stall_left;

    function automatic void place_word(int len, int sp, bit eol);
        gtlj_pkg::result_item_t r;
        r.out_word_length = gtlj_pkg::LEN_W'(len);
        // space counts saturate at the field maximum
        r.spaces_after    = (sp > int'(gtlj_pkg::SP_MAX)) ? gtlj_pkg::SP_MAX
                                                          : gtlj_pkg::SP_W'(sp);
        r.end_of_line     = eol;
        r.last_result     = 1'b0;
        step_results = {step_results, r};
    endfunction

    // Send out the buffered line. closing = left-justified final line.
    function automatic void flush_line_words(bit closing);
        int n;
        int pad;
        int gaps;
        int each;
        int extra;
        int rest;
        n = line_words;
        if (n == 0)
            return;
        // padding clamps at zero when the letters overrun the width
        pad = (int'(cur_width) > line_letters) ? int'(cur_width) - line_letters : 0;
        if (closing)
        begin
            for (int j = 0; j < n - 1; j++)
                place_word(line_lens[j], 1, 1'b0);
            rest = (pad > n - 1) ? pad - (n - 1) : 0;
            place_word(line_lens[n-1], rest, 1'b1);
        end
        else if (n == 1)
        begin
            place_word(line_lens[0], pad, 1'b1);
        end
        else
        begin
            // even split, leftmost gaps take the remainder
            gaps  = n - 1;
            each  = pad / gaps;
            extra = pad % gaps;
            for (int j = 0; j < gaps; j++)
                place_word(line_lens[j], each + ((j < extra) ? 1 : 0), 1'b0);
            place_word(line_lens[gaps], 0, 1'b1);
        end
        line_words   = 0;
        line_letters = 0;
    endfunction

    // Predict the results caused by one accepted word item.
    function automatic void justify_word(gtlj_pkg::word_item_t w);
        int len;
        int n;
        gtlj_pkg::result_item_t r;
        len = w.word_length;
        step_results.delete();
        // word does not fit, or the buffer is full: flush justified first
        if (line_words > 0 &&
            (line_words >= gtlj_pkg::MAX_WORDS ||
             line_letters + len + line_words > int'(cur_width)))
            flush_line_words(1'b0);
        if (line_words < gtlj_pkg::MAX_WORDS)
        begin
            line_lens[line_words] = w.word_length;
            line_words++;
            line_letters += len;
        end
        if (w.end_of_text)
            flush_line_words(1'b1);
        n = step_results.size();
        if (n > 0)
        begin
            r = step_results[n-1];
            r.last_result = 1'b1;
            step_results[n-1] = r;
        end
    endfunction

    // -----------------------------------------------------------------------
    // Word side driver; called at a falling edge, returns at a falling edge
    // with word_valid still high so a gapless next item needs one assignment
    // -----------------------------------------------------------------------
    task automatic send_word(input int len, input bit eot, input bit typed,
                             input gtlj_pkg::result_item_t fixed);
        gtlj_pkg::word_item_t w;
        int gap;
        w.word_length = gtlj_pkg::LEN_W'(len);
        w.end_of_text = eot;
        gap = no_idle ? 0 : $urandom_range(16, 0);
        if (gap > 0)
        begin
            word_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        word_item  = w;
        word_valid = 1'b1;
        do
            @(posedge clk);
        while (word_stall);
        justify_word(w);
        if (typed)
            awaited_results = {awaited_results, fixed};
        else
            foreach (step_results[i])
                awaited_results = {awaited_results, step_results[i]};
        @(negedge clk);
    endtask

    // Wait for the block to go idle, then write line_width.
    task automatic write_line_width(input int value);
        word_valid = 1'b0;
        while (awaited_results.size() != 0)
            @(negedge clk);
        // words that cause no result may still be in flight
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_write_en   = 1'b1;
        cfg_write_data = gtlj_pkg::LEN_W'(value);
        @(negedge clk);
        cfg_write_en = 1'b0;
        cur_width    = gtlj_pkg::LEN_W'(value);
    endtask

    function automatic void add_row(row_kind_t kind, int value, bit eot, int fixed_sp);
        stim_row_t row;
        row.kind  = kind;
        row.value = value;
        row.eot   = eot;
        // typed rows are always a lone word on a closing line
        row.fixed.out_word_length = gtlj_pkg::LEN_W'(value);
        row.fixed.spaces_after    = gtlj_pkg::SP_W'(fixed_sp);
        row.fixed.end_of_line     = 1'b1;
        row.fixed.last_result     = 1'b1;
        directed_rows = {directed_rows, row};
    endfunction

    // -----------------------------------------------------------------------
    // Result side: random stall, compare against the oldest expectation
    // -----------------------------------------------------------------------
    initial
    begin
        gtlj_pkg::result_item_t want;
        stall_left   = 0;
        result_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= MAX_REPORTS)
                        $display("unexpected result item: len %0d sp %0d eol %0b last %0b",
                                 result_item.out_word_length, result_item.spaces_after,
                                 result_item.end_of_line, result_item.last_result);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (result_item.out_word_length !== want.out_word_length ||
                        result_item.spaces_after    !== want.spaces_after    ||
                        result_item.end_of_line     !== want.end_of_line     ||
                        result_item.last_result     !== want.last_result)
                    begin
                        fault_count++;
                        if (fault_count <= MAX_REPORTS)
                            $display({"result mismatch: exp len %0d sp %0d eol %0b last %0b,",
                                      " got len %0d sp %0d eol %0b last %0b"},
                                     want.out_word_length, want.spaces_after,
                                     want.end_of_line, want.last_result,
                                     result_item.out_word_length, result_item.spaces_after,
                                     result_item.end_of_line, result_item.last_result);
                    end
                end
                stall_left = no_idle ? 0 : $urandom_range(16, 0);
            end
            @(negedge clk);
            result_stall = (stall_left > 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    // Watchdog: no item moving on either channel for too long
    int quiet_cycles = 0;
    always @(posedge clk)
    begin
        if ((word_valid && !word_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_greedy_text_line_justifier_unit: errors");
            $finish;
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus
    // -----------------------------------------------------------------------
    initial
    begin
        int sent;
        int batch;
        int len;
        int span;
        int pick;
        int lo;
        int width;
        bit dense;
        bit eot;

        rst_n          = 1'b0;
        cfg_write_en   = 1'b0;
        cfg_write_data = '0;
        word_valid     = 1'b0;
        word_item      = '0;
        no_idle        = 1'b0;
        fault_count    = 0;
        cur_width      = gtlj_pkg::LINE_WIDTH_RESET;
        line_letters   = 0;
        line_words     = 0;
        foreach (line_lens[i])
            line_lens[i] = '0;

        // Directed table. Reset width first: lone words at the extremes.
        add_row(ROW_TYPED, 64, 1'b1, 0);      // exact fit
        add_row(ROW_TYPED, 1, 1'b1, 63);
        add_row(ROW_TYPED, 127, 1'b1, 0);     // overlong, padding clamps
        add_row(ROW_TYPED, 0, 1'b1, 63);      // zero length, 64 saturates
        // three-word justified line, then a two-word closing line
        add_row(ROW_WORD, 10, 1'b0, 0);
        add_row(ROW_WORD, 20, 1'b0, 0);
        add_row(ROW_WORD, 30, 1'b0, 0);
        add_row(ROW_WORD, 5, 1'b0, 0);
        add_row(ROW_WORD, 40, 1'b1, 0);
        // uneven split: remainder goes to the left gap
        add_row(ROW_WORD, 5, 1'b0, 0);
        add_row(ROW_WORD, 6, 1'b0, 0);
        add_row(ROW_WORD, 8, 1'b0, 0);
        add_row(ROW_WORD, 50, 1'b1, 0);
        // width narrowed under a half-built line: gaps get 0 spaces
        add_row(ROW_WORD, 20, 1'b0, 0);
        add_row(ROW_WORD, 20, 1'b0, 0);
        add_row(ROW_WIDTH, 10, 1'b0, 0);
        add_row(ROW_WORD, 5, 1'b1, 0);
        // smallest widths
        add_row(ROW_WIDTH, 1, 1'b0, 0);
        add_row(ROW_TYPED, 0, 1'b1, 1);
        add_row(ROW_WORD, 1, 1'b0, 0);
        add_row(ROW_WORD, 1, 1'b1, 0);
        add_row(ROW_WIDTH, 0, 1'b0, 0);
        add_row(ROW_TYPED, 5, 1'b1, 0);
        add_row(ROW_WORD, 0, 1'b0, 0);
        add_row(ROW_WORD, 0, 1'b1, 0);
        // widest register value
        add_row(ROW_WIDTH, 127, 1'b0, 0);
        add_row(ROW_TYPED, 1, 1'b1, 63);      // 126 spaces saturate
        add_row(ROW_WORD, 64, 1'b0, 0);
        add_row(ROW_WORD, 62, 1'b1, 0);       // exactly fills 127

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            case (directed_rows[i].kind)
                ROW_WIDTH: write_line_width(directed_rows[i].value);
                ROW_WORD:  send_word(directed_rows[i].value, directed_rows[i].eot,
                                     1'b0, directed_rows[i].fixed);
                default:   send_word(directed_rows[i].value, directed_rows[i].eot,
                                     1'b1, directed_rows[i].fixed);
            endcase
        end

        // Random phases: new width, then a run of words. Some phases end
        // without end of text so the next width applies to a partial line.
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            dense = ($urandom_range(4, 0) == 0);
            if (dense)
                width = ($urandom_range(3, 0) == 0) ? 64 : 127;
            else
            begin
                case ($urandom_range(9, 0))
                    0:       width = 0;
                    1:       width = 1;
                    2:       width = 127;
                    3:       width = 64;
                    default: width = $urandom_range(64, 2);
                endcase
            end
            write_line_width(width);
            no_idle = ($urandom_range(3, 0) == 0);
            // dense phases of tiny words fill all MAX_WORDS slots
            batch = dense ? $urandom_range(45, 36) : $urandom_range(25, 8);
            span  = (width / 3 > 1) ? width / 3 : 1;
            for (int k = 0; k < batch; k++)
            begin
                pick = $urandom_range(9, 0);
                if (dense)
                    len = $urandom_range(1, 0);
                else if (pick == 0)
                    len = $urandom_range(127, 0);
                else if (pick == 1)
                begin
                    // near the width, either side of a fit
                    lo  = (width > 4) ? width - 4 : 0;
                    len = $urandom_range(width + 1, lo);
                end
                else
                    len = $urandom_range(span, 1);
                if (k == batch - 1)
                    eot = ($urandom_range(3, 0) != 0);
                else
                    eot = ($urandom_range(11, 0) == 0) && !dense;
                send_word(len, eot, 1'b0, '0);
            end
            sent += batch;
            no_idle = 1'b0;
        end

        word_valid = 1'b0;
        while (awaited_results.size() != 0)
            @(negedge clk);
        // catch any stray result item after the last expected one
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (fault_count == 0)
            $display("tb_greedy_text_line_justifier_unit: clean");
        else
            $display("tb_greedy_text_line_justifier_unit: errors");
        $finish;
    end

endmodule
